// ----- design/sfms_pkg.sv -----
`default_nettype none

package sfms_pkg;

    localparam int MAX_LEN = 256;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int POS_W   = 9;
    localparam int CH_W    = 8;
    localparam int KIND_W  = 2;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CH_W-1:0]  t_ch;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAT = 2'd0,
        KIND_TXT = 2'd1,
        KIND_END = 2'd2
    } t_kind;

    // control from the sequencing logic to the compare cells
    typedef struct packed {
        logic pat_wr;
        t_idx pat_idx;
        logic txt_step;
        logic clear;
        t_ch  ch;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- design/sfms_if.sv -----
`default_nettype none

interface sfms_in_if;
    logic                              valid;
    logic                              ready;
    logic [sfms_pkg::KIND_W-1:0]       kind;
    logic [sfms_pkg::CH_W-1:0]         ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink   (input valid, input kind, input ch, output ready);
endinterface

interface sfms_out_if;
    logic                              valid;
    logic                              ready;
    logic [sfms_pkg::POS_W-1:0]        position;
    logic                              overflow;

    modport source (output valid, output position, output overflow, input ready);
    modport sink   (input valid, input position, input overflow, output ready);
endinterface

`default_nettype wire

// ----- design/sfms_cells.sv -----
`default_nettype none

// Row of compare cells. Cell j holds pattern byte j and a flag that says the
// text seen so far ends with the first j+1 pattern bytes (shift-and form).
module sfms_cells (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sfms_pkg::t_cell_ctrl i_ctrl,
    input  wire sfms_pkg::t_idx      i_sel,
    output logic                     o_hit
);

    sfms_pkg::t_ch                   r_pat [sfms_pkg::MAX_LEN];
    logic [sfms_pkg::MAX_LEN-1:0]    r_pre;
    logic [sfms_pkg::MAX_LEN-1:0]    n_pre;

    for (genvar j = 0; j < sfms_pkg::MAX_LEN; j++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_ctrl.pat_wr && (i_ctrl.pat_idx == sfms_pkg::t_idx'(j))) begin
                r_pat[j] <= i_ctrl.ch;
            end
        end

        if (j == 0) begin : g_first
            assign n_pre[j] = (i_ctrl.ch == r_pat[j]);
        end else begin : g_rest
            assign n_pre[j] = r_pre[j-1] && (i_ctrl.ch == r_pat[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_pre <= '0;
        end else if (i_ctrl.txt_step) begin
            r_pre <= n_pre;
        end
    end

    // full-pattern match for the byte being shifted in now
    assign o_hit = n_pre[i_sel];

endmodule

`default_nettype wire

// ----- design/substring_first_match_search_top.sv -----
`default_nettype none

// channel   dir  signals                          meaning
// i_in      in   valid ready kind[1:0] ch[7:0]    pattern byte, text byte, end of text
// o_out     out  valid ready position[8:0] overflow  one result per end-of-text item
//
// One item per cycle sustained while no held result stalls an end-of-text item. The
// end-of-text item passes through the input stage, then the result register, which
// loads as the item leaves the input stage.
// Each text byte updates the whole row of compare cells at once.
// Synchronous active-low reset clears the search state and both stages.
// A held result stalls only an end-of-text item in the input stage, and
// that backs up into i_in.ready; pattern and text bytes keep flowing.
module substring_first_match_search_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sfms_in_if.sink     i_in,
    sfms_out_if.source  o_out
);

    // input stage
    logic               r_stg_valid;
    sfms_pkg::t_kind    r_kind;
    sfms_pkg::t_ch      r_ch;

    // search state
    sfms_pkg::t_cnt     r_pat_len, n_pat_len;
    sfms_pkg::t_cnt     r_txt_cnt, n_txt_cnt;
    logic               r_found, n_found;
    sfms_pkg::t_pos     r_mpos, n_mpos;
    logic               r_ovf, n_ovf;

    // result register
    logic               r_out_valid;
    sfms_pkg::t_pos     r_out_pos, n_out_pos;
    logic               r_out_ovf;
    logic               out_load;

    logic               stg_go;
    sfms_pkg::t_cnt     len_m1;
    sfms_pkg::t_cell_ctrl cell_ctrl;
    logic               hit;

    assign stg_go     = r_stg_valid &&
                        !((r_kind == sfms_pkg::KIND_END) && r_out_valid && !o_out.ready);
    assign i_in.ready = !r_stg_valid || stg_go;
    assign len_m1     = r_pat_len - sfms_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_stg_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_kind <= sfms_pkg::t_kind'(i_in.kind);
            r_ch   <= i_in.ch;
        end
    end

    sfms_cells u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cell_ctrl),
        .i_sel   (len_m1[sfms_pkg::IDX_W-1:0]),
        .o_hit   (hit)
    );

    always_comb begin
        n_pat_len          = r_pat_len;
        n_txt_cnt          = r_txt_cnt;
        n_found            = r_found;
        n_mpos             = r_mpos;
        n_ovf              = r_ovf;
        n_out_pos          = '0;
        out_load           = 1'b0;
        cell_ctrl          = '0;
        cell_ctrl.ch       = r_ch;
        cell_ctrl.pat_idx  = r_pat_len[sfms_pkg::IDX_W-1:0];
        if (stg_go) begin
            unique case (r_kind)
                sfms_pkg::KIND_PAT: begin
                    // pattern bytes after text has started are dropped
                    if (r_txt_cnt == '0) begin
                        if (r_pat_len < sfms_pkg::CNT_W'(sfms_pkg::MAX_LEN)) begin
                            cell_ctrl.pat_wr = 1'b1;
                            n_pat_len        = r_pat_len + sfms_pkg::CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                sfms_pkg::KIND_TXT: begin
                    if (r_txt_cnt >= sfms_pkg::CNT_W'(sfms_pkg::MAX_LEN)) begin
                        n_ovf = 1'b1;
                    end else begin
                        cell_ctrl.txt_step = 1'b1;
                        n_txt_cnt          = r_txt_cnt + sfms_pkg::CNT_W'(1);
                        if (!r_found && (r_pat_len != '0) && hit) begin
                            n_found = 1'b1;
                            n_mpos  = sfms_pkg::t_pos'(n_txt_cnt - r_pat_len
                                                       + sfms_pkg::CNT_W'(1));
                        end
                    end
                end
                sfms_pkg::KIND_END: begin
                    out_load        = 1'b1;
                    cell_ctrl.clear = 1'b1;
                    if (r_pat_len == '0) begin
                        n_out_pos = sfms_pkg::t_pos'(1);
                    end else if (r_found) begin
                        n_out_pos = r_mpos;
                    end
                    n_pat_len = '0;
                    n_txt_cnt = '0;
                    n_found   = 1'b0;
                    n_mpos    = '0;
                    n_ovf     = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_txt_cnt <= '0;
            r_found   <= 1'b0;
            r_mpos    <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_pat_len <= n_pat_len;
            r_txt_cnt <= n_txt_cnt;
            r_found   <= n_found;
            r_mpos    <= n_mpos;
            r_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos <= n_out_pos;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_out_pos;
    assign o_out.overflow = r_out_ovf;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out.valid && (r_pat_len == '0) && (r_txt_cnt == '0) && !r_found))
        else $error("end of text did not present a result and clear the search");

    a_found_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> ((r_pat_len != '0) && (r_txt_cnt >= r_pat_len)))
        else $error("match recorded with empty pattern or too little text");

    a_pat_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_txt_cnt != '0) && !out_load) |=> $stable(r_pat_len))
        else $error("pattern length changed while text was streaming");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !out_load)
        else $error("result register loaded while a result was pending");

endmodule

`default_nettype wire
